// ----- design/omp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omp_pkg: shared types and constants of the optical meter pulse counter
// clock limits, bin sizes, register indexes, sequencer states, alu codes
// ----------------------------------------------------------------------------
package omp_pkg;

	// default parameter values
	localparam int OMP_RING_DEPTH  = 16;
	localparam int OMP_SAMPLE_BITS = 12;

	// field widths
	localparam int THR_W      = 12;
	localparam int TPS_W      = 16;
	localparam int BIN_W      = 8;
	localparam int SEC_W      = 6;
	localparam int MIN_W      = 6;
	localparam int HOUR_W     = 5;
	localparam int DAY_W      = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// clock and bin limits
	localparam int SECONDS_PER_MINUTE = 60;
	localparam int MIN_BINS           = 60;
	localparam int HOUR_BINS          = 24;
	localparam int DAY_BINS           = 31;
	localparam int WIN_MINUTES        = 15;
	localparam int WIN_CNT_W          = $clog2(WIN_MINUTES + 1);

	// reset values of the registers
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TICKS     = CFG_IDX_W'(1);

	typedef enum logic [0:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUB_OLD,
		ST_ADD_NEW,
		ST_DIFF,
		ST_MUL,
		ST_CMP,
		ST_BIN_M,
		ST_BIN_H,
		ST_BIN_D,
		ST_BIN_A,
		ST_WIN,
		ST_EMIT
	} state_t;

endpackage

// ----- design/omp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omp_ram: generic simple dual port ram
// one write port, one read port, registered read data held when not reading
// ----------------------------------------------------------------------------
module omp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/omp_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omp_alu: shared add / subtract unit
// result carries one extra bit: carry on add, borrow on subtract
// ----------------------------------------------------------------------------
module omp_alu #(
	parameter int W = 16
) (
	input  omp_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [W:0]       res
);
	import omp_pkg::*;

	always_comb begin
		unique case (op)
			ALU_ADD: res = {1'b0, a} + {1'b0, b};
			ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default: res = '0;
		endcase
	end

endmodule

// ----- design/optical_meter_pulse_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_meter_pulse_counter: pulse detector and minute / hour / day binning
// one input word per timer tick, one result word per newly detected pulse
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_ready carries one sample word per tick
//   output channel out_valid / out_ready carries one result word per new pulse
//   cfg_we writes cfg_data into register cfg_index (0 threshold, 1 ticks per
//   second); the user must write only while the block is idle (not enforced)
// sequence
//   a tick without a new pulse steps through sub old, add new, diff, mul and
//   cmp before in_ready rises again; a tick with a new pulse goes on through
//   the bin states and the window sweep to emit, where the result appears;
//   the sequence is set by the sequencer driving one shared adder: ring sum
//   update, threshold compare, three bin increments, the all-hours count and
//   a 15 step sweep of the minute bin ram through its single read port
// reset
//   after arst_n releases, a clearing pass zeroes the ring and bin rams,
//   during which in_ready stays low
// stall
//   the result sits in an output register; the next tick is accepted while
//   it waits, a second result waits in the sequencer until the first is taken
// ----------------------------------------------------------------------------
module optical_meter_pulse_counter #(
	parameter int RING_DEPTH  = omp_pkg::OMP_RING_DEPTH,
	parameter int SAMPLE_BITS = omp_pkg::OMP_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [omp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [omp_pkg::CFG_DATA_W-1:0] cfg_data,
	// sample word
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [SAMPLE_BITS-1:0]         sample,
	// result word
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [omp_pkg::BIN_W-1:0]      count_last_15_minutes,
	output logic [omp_pkg::BIN_W-1:0]      count_this_hour,
	output logic [omp_pkg::BIN_W-1:0]      count_all_hours,
	output logic [omp_pkg::MIN_W-1:0]      minute_now,
	output logic [omp_pkg::HOUR_W-1:0]     hour_now,
	output logic [omp_pkg::DAY_W-1:0]      day_now
);
	import omp_pkg::*;

	// ring address width and shared datapath width (sum, product, compare)
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int OP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int W       = OP_W + RING_AW;
	localparam int CLR_LEN = (RING_DEPTH > MIN_BINS) ? RING_DEPTH : MIN_BINS;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int MIN_AW  = $clog2(MIN_BINS);
	localparam int HOUR_AW = $clog2(HOUR_BINS);
	localparam int DAY_AW  = $clog2(DAY_BINS);

	localparam logic [W-1:0]       DEPTH_W   = W'(RING_DEPTH);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
	localparam logic [CLR_W-1:0]   CLR_LAST  = CLR_W'(CLR_LEN - 1);

	// configuration registers
	logic [THR_W-1:0] thr_q;
	logic [TPS_W-1:0] tps_q;

	// sequencer
	state_t state_q, state_d;
	logic [CLR_W-1:0]     clr_q;
	logic [WIN_CNT_W-1:0] win_cnt_q;

	// time of day
	logic [TPS_W-1:0]  tick_q,  tick_d;
	logic [SEC_W-1:0]  sec_q,   sec_d;
	logic [MIN_W-1:0]  min_q,   min_d;
	logic [HOUR_W-1:0] hour_q,  hour_d;
	logic [DAY_W-1:0]  day_q,   day_d;

	// detection datapath
	logic [SAMPLE_BITS-1:0] s_q;
	logic [RING_AW-1:0]     pos_q;
	logic [W-1:0]           sum_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic                   gt_q;
	logic [W-1:0]           prod_q;
	logic                   above_q;
	logic                   above;

	// binning datapath
	logic [BIN_W-1:0]  hour_new_q;
	logic [BIN_W-1:0]  all_q;
	logic [BIN_W-1:0]  win_q;
	logic [MIN_AW-1:0] widx_q;

	// output register
	logic             out_valid_q;
	logic [BIN_W-1:0] o_win_q, o_hour_q, o_all_q;
	logic [MIN_W-1:0] o_min_q;
	logic [HOUR_W-1:0] o_hr_q;
	logic [DAY_W-1:0] o_day_q;

	// shared unit
	alu_op_t     alu_op;
	logic [W-1:0] alu_a, alu_b;
	logic [W:0]   alu_res;

	// ram ports
	logic                   ring_we, ring_re;
	logic [RING_AW-1:0]     ring_waddr, ring_raddr;
	logic [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
	logic                   min_we, min_re;
	logic [MIN_AW-1:0]      min_waddr, min_raddr;
	logic [BIN_W-1:0]       min_wdata, min_rdata;
	logic                   hr_we, hr_re;
	logic [HOUR_AW-1:0]     hr_waddr, hr_raddr;
	logic [BIN_W-1:0]       hr_wdata, hr_rdata;
	logic                   day_we, day_re;
	logic [DAY_AW-1:0]      day_waddr, day_raddr;
	logic [BIN_W-1:0]       day_wdata, day_rdata;

	logic in_acc, emit_go, new_pulse;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	// sum below depth times margin means the sample clears the average
	assign above     = gt_q && alu_res[W];
	assign new_pulse = above && !above_q;

	omp_alu #(.W(W)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	omp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	omp_ram #(.WIDTH(BIN_W), .DEPTH(MIN_BINS)) u_min_bins (
		.clk  (clk),
		.we   (min_we),
		.waddr(min_waddr),
		.wdata(min_wdata),
		.re   (min_re),
		.raddr(min_raddr),
		.rdata(min_rdata)
	);

	omp_ram #(.WIDTH(BIN_W), .DEPTH(HOUR_BINS)) u_hour_bins (
		.clk  (clk),
		.we   (hr_we),
		.waddr(hr_waddr),
		.wdata(hr_wdata),
		.re   (hr_re),
		.raddr(hr_raddr),
		.rdata(hr_rdata)
	);

	omp_ram #(.WIDTH(BIN_W), .DEPTH(DAY_BINS)) u_day_bins (
		.clk  (clk),
		.we   (day_we),
		.waddr(day_waddr),
		.wdata(day_wdata),
		.re   (day_re),
		.raddr(day_raddr),
		.rdata(day_rdata)
	);

	// time of day advance for one tick
	always_comb begin
		tick_d = tick_q + TPS_W'(1);
		sec_d  = sec_q;
		min_d  = min_q;
		hour_d = hour_q;
		day_d  = day_q;
		if (tick_d == tps_q) begin
			tick_d = '0;
			if (sec_q == SEC_W'(SECONDS_PER_MINUTE - 1)) begin
				sec_d = '0;
				if (min_q == MIN_W'(MIN_BINS - 1)) begin
					min_d = '0;
					if (hour_q == HOUR_W'(HOUR_BINS - 1)) begin
						hour_d = '0;
						day_d  = (day_q == DAY_W'(DAY_BINS - 1)) ? '0 : day_q + DAY_W'(1);
					end else begin
						hour_d = hour_q + HOUR_W'(1);
					end
				end else begin
					min_d = min_q + MIN_W'(1);
				end
			end else begin
				sec_d = sec_q + SEC_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE:    if (in_acc) state_d = ST_SUB_OLD;
			ST_SUB_OLD: state_d = ST_ADD_NEW;
			ST_ADD_NEW: state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_MUL;
			ST_MUL:     state_d = ST_CMP;
			ST_CMP:     state_d = new_pulse ? ST_BIN_M : ST_IDLE;
			ST_BIN_M:   state_d = ST_BIN_H;
			ST_BIN_H:   state_d = ST_BIN_D;
			ST_BIN_D:   state_d = ST_BIN_A;
			ST_BIN_A:   state_d = ST_WIN;
			ST_WIN:     if (win_cnt_q == WIN_CNT_W'(WIN_MINUTES)) state_d = ST_EMIT;
			ST_EMIT:    if (emit_go) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	// sequencer outputs: alu operands and ram ports
	always_comb begin
		alu_op     = ALU_ADD;
		alu_a      = '0;
		alu_b      = '0;
		ring_we    = 1'b0;
		ring_waddr = pos_q;
		ring_wdata = s_q;
		ring_re    = 1'b0;
		ring_raddr = pos_q;
		min_we     = 1'b0;
		min_waddr  = min_q;
		min_wdata  = alu_res[BIN_W-1:0];
		min_re     = 1'b0;
		min_raddr  = min_q;
		hr_we      = 1'b0;
		hr_waddr   = hour_q;
		hr_wdata   = alu_res[BIN_W-1:0];
		hr_re      = 1'b0;
		hr_raddr   = hour_q;
		day_we     = 1'b0;
		day_waddr  = day_q;
		day_wdata  = alu_res[BIN_W-1:0];
		day_re     = 1'b0;
		day_raddr  = day_q;
		unique case (state_q)
			ST_CLEAR: begin
				ring_we    = ({1'b0, clr_q} < (CLR_W + 1)'(RING_DEPTH));
				ring_waddr = clr_q[RING_AW-1:0];
				ring_wdata = '0;
				min_we     = ({1'b0, clr_q} < (CLR_W + 1)'(MIN_BINS));
				min_waddr  = clr_q[MIN_AW-1:0];
				min_wdata  = '0;
				hr_we      = ({1'b0, clr_q} < (CLR_W + 1)'(HOUR_BINS));
				hr_waddr   = clr_q[HOUR_AW-1:0];
				hr_wdata   = '0;
				day_we     = ({1'b0, clr_q} < (CLR_W + 1)'(DAY_BINS));
				day_waddr  = clr_q[DAY_AW-1:0];
				day_wdata  = '0;
			end
			// fetch the ring entry about to be replaced
			ST_IDLE: ring_re = in_acc;
			ST_SUB_OLD: begin
				alu_op = ALU_SUB;
				alu_a  = sum_q;
				alu_b  = W'(ring_rdata);
			end
			ST_ADD_NEW: begin
				alu_a   = sum_q;
				alu_b   = W'(s_q);
				ring_we = 1'b1;
			end
			ST_DIFF: begin
				alu_op = ALU_SUB;
				alu_a  = W'(s_q);
				alu_b  = W'(thr_q);
			end
			ST_MUL: begin
			end
			ST_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = sum_q;
				alu_b  = prod_q;
				min_re = 1'b1;
				hr_re  = 1'b1;
				day_re = 1'b1;
			end
			ST_BIN_M: begin
				alu_a  = W'(min_rdata);
				alu_b  = W'(1);
				min_we = 1'b1;
			end
			ST_BIN_H: begin
				alu_a = W'(hr_rdata);
				alu_b = W'(1);
				hr_we = 1'b1;
			end
			ST_BIN_D: begin
				alu_a  = W'(day_rdata);
				alu_b  = W'(1);
				day_we = 1'b1;
			end
			ST_BIN_A: begin
				alu_a = W'(all_q);
				alu_b = W'(1);
			end
			// window sweep: read one minute bin, add the one read before
			ST_WIN: begin
				alu_a     = W'(win_q);
				alu_b     = W'(min_rdata);
				min_re    = (win_cnt_q != WIN_CNT_W'(WIN_MINUTES));
				min_raddr = widx_q;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			thr_q       <= THR_RESET;
			tps_q       <= TPS_RESET;
			tick_q      <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			above_q     <= 1'b0;
			all_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cfg_we) begin
				if (cfg_index == REG_THRESHOLD) begin
					thr_q <= cfg_data[THR_W-1:0];
				end else if (cfg_index == REG_TICKS) begin
					tps_q <= cfg_data[TPS_W-1:0];
				end
			end
			if (in_acc) begin
				tick_q <= tick_d;
				sec_q  <= sec_d;
				min_q  <= min_d;
				hour_q <= hour_d;
				day_q  <= day_d;
			end
			if (state_q == ST_SUB_OLD || state_q == ST_ADD_NEW) begin
				sum_q <= alu_res[W-1:0];
			end
			if (state_q == ST_ADD_NEW) begin
				pos_q <= (pos_q == RING_LAST) ? '0 : pos_q + RING_AW'(1);
			end
			if (state_q == ST_CMP) begin
				above_q <= above;
			end
			if (state_q == ST_BIN_A) begin
				all_q <= alu_res[BIN_W-1:0];
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= sample;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= alu_res[SAMPLE_BITS-1:0];
			gt_q   <= !alu_res[W] && (alu_res[W-1:0] != '0);
		end
		if (state_q == ST_MUL) begin
			prod_q <= W'(diff_q) * DEPTH_W;
		end
		if (state_q == ST_BIN_H) begin
			hour_new_q <= alu_res[BIN_W-1:0];
		end
		if (state_q == ST_BIN_A) begin
			win_q     <= '0;
			win_cnt_q <= '0;
			widx_q    <= min_q;
		end
		if (state_q == ST_WIN) begin
			win_cnt_q <= win_cnt_q + WIN_CNT_W'(1);
			widx_q    <= (widx_q == '0) ? MIN_AW'(MIN_BINS - 1) : widx_q - MIN_AW'(1);
			if (win_cnt_q != '0) begin
				win_q <= alu_res[BIN_W-1:0];
			end
		end
		if (emit_go) begin
			o_win_q  <= win_q;
			o_hour_q <= hour_new_q;
			o_all_q  <= all_q;
			o_min_q  <= min_q;
			o_hr_q   <= hour_q;
			o_day_q  <= day_q;
		end
	end

	assign out_valid             = out_valid_q;
	assign count_last_15_minutes = o_win_q;
	assign count_this_hour       = o_hour_q;
	assign count_all_hours       = o_all_q;
	assign minute_now            = o_min_q;
	assign hour_now              = o_hr_q;
	assign day_now               = o_day_q;

endmodule

// ----- test/tb_optical_meter_pulse_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_optical_meter_pulse_counter: self-checking bench of the pulse counter
// drives sample words with random gaps and random result stalls, predicts
// each new pulse with a behavioral copy of the meter (ring average, clock,
// minute / hour / day bins) and checks every result word field by field.
// several register settings are visited, a back-to-back sweep at one tick
// per second crosses minute boundaries.
// ----------------------------------------------------------------------------
module tb_optical_meter_pulse_counter;
	import omp_pkg::*;

	// timing of the bench
	localparam int MAX_WAIT    = 10;    // longest idle gap of either side
	localparam int HOLD_OFF    = 40;    // covers a tick still in the sequencer
	localparam int STALL_LIMIT = 2000;  // cycles with no word moving on any side
	localparam int SWEEP_TICKS = 150;   // a few minutes at one tick per second
	localparam int FLASH_EVERY = 13;    // flash spacing during the sweep

	// register indexes that the block has to ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = CFG_IDX_W'(15);

	localparam logic [OMP_SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	// one result word
	typedef struct packed {
		logic [BIN_W-1:0]  window_sum;
		logic [BIN_W-1:0]  hour_total;
		logic [BIN_W-1:0]  all_hours;
		logic [MIN_W-1:0]  minute;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
	} pulse_report_t;

	// behavioral copy of the meter plus the queue of pulse reports still owed
	class pulse_tracker;
		logic [THR_W-1:0]           threshold;
		logic [TPS_W-1:0]           ticks_per_sec;
		logic [OMP_SAMPLE_BITS-1:0] ring [OMP_RING_DEPTH];
		int                         ring_pos;
		bit                         above_prev;
		logic [TPS_W-1:0]           tick;
		int                         sec_cnt;
		int                         min_cnt;
		int                         hour_cnt;
		int                         day_cnt;
		logic [BIN_W-1:0]           min_bin [MIN_BINS];
		logic [BIN_W-1:0]           hour_bin [HOUR_BINS];
		logic [BIN_W-1:0]           day_bin [DAY_BINS];
		pulse_report_t              owed [$];

		function new();
			threshold     = THR_RESET;
			ticks_per_sec = TPS_RESET;
			foreach (ring[k]) ring[k] = '0;
			foreach (min_bin[k]) min_bin[k] = '0;
			foreach (hour_bin[k]) hour_bin[k] = '0;
			foreach (day_bin[k]) day_bin[k] = '0;
			ring_pos   = 0;
			above_prev = 0;
			tick       = '0;
			sec_cnt    = 0;
			min_cnt    = 0;
			hour_cnt   = 0;
			day_cnt    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_THRESHOLD)
				threshold = data[THR_W-1:0];
			else if (idx == REG_TICKS)
				ticks_per_sec = data[TPS_W-1:0];
		endfunction

		// floor average of the ring with s in the slot about to be written
		function int ring_avg(logic [OMP_SAMPLE_BITS-1:0] s);
			int sum;
			sum = 0;
			for (int k = 0; k < OMP_RING_DEPTH; k++)
				sum += (k == ring_pos) ? int'(s) : int'(ring[k]);
			return sum / OMP_RING_DEPTH;
		endfunction

		// smallest sample that lands at least margin above the average
		function logic [OMP_SAMPLE_BITS-1:0] at_margin(int margin);
			int avg;
			for (int s = 0; s <= int'(SAMPLE_MAX); s++) begin
				avg = ring_avg(OMP_SAMPLE_BITS'(s));
				if (s > avg && s - avg >= margin)
					return OMP_SAMPLE_BITS'(s);
			end
			return SAMPLE_MAX;
		endfunction

		function void note_sample(logic [OMP_SAMPLE_BITS-1:0] s);
			int            avg;
			bit            above;
			pulse_report_t rpt;
			logic [BIN_W-1:0] win;
			logic [BIN_W-1:0] all;

			// clock first, the counter wraps through 65536
			tick = tick + 1'b1;
			if (tick == ticks_per_sec) begin
				tick = '0;
				sec_cnt++;
				if (sec_cnt == SECONDS_PER_MINUTE) begin
					sec_cnt = 0;
					min_cnt++;
					if (min_cnt == MIN_BINS) begin
						min_cnt = 0;
						hour_cnt++;
						if (hour_cnt == HOUR_BINS) begin
							hour_cnt = 0;
							day_cnt++;
							if (day_cnt == DAY_BINS)
								day_cnt = 0;
						end
					end
				end
			end

			avg = ring_avg(s);
			ring[ring_pos] = s;
			above = (int'(s) > avg) && (int'(s) - avg > int'(threshold));

			if (above && !above_prev) begin
				min_bin[min_cnt]   = min_bin[min_cnt] + 1'b1;
				hour_bin[hour_cnt] = hour_bin[hour_cnt] + 1'b1;
				day_bin[day_cnt]   = day_bin[day_cnt] + 1'b1;
				win = '0;
				all = '0;
				for (int k = 0; k < WIN_MINUTES; k++)
					win = win + min_bin[(min_cnt + MIN_BINS - k) % MIN_BINS];
				for (int k = 0; k < HOUR_BINS; k++)
					all = all + hour_bin[k];
				rpt.window_sum = win;
				rpt.hour_total = hour_bin[hour_cnt];
				rpt.all_hours  = all;
				rpt.minute     = MIN_W'(min_cnt);
				rpt.hour       = HOUR_W'(hour_cnt);
				rpt.day        = DAY_W'(day_cnt);
				owed.push_back(rpt);
			end
			above_prev = above;
			ring_pos   = (ring_pos + 1) % OMP_RING_DEPTH;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// empty string when the word matches the oldest owed report
		function string check(pulse_report_t got);
			pulse_report_t want;
			string         diff;
			if (owed.size() == 0)
				return $sformatf("result word with no pulse pending: %p", got);
			want = owed.pop_front();
			diff = "";
			if (got.window_sum != want.window_sum)
				diff = {diff, $sformatf(" 15min %0d/%0d", got.window_sum, want.window_sum)};
			if (got.hour_total != want.hour_total)
				diff = {diff, $sformatf(" this_hour %0d/%0d", got.hour_total, want.hour_total)};
			if (got.all_hours != want.all_hours)
				diff = {diff, $sformatf(" all_hours %0d/%0d", got.all_hours, want.all_hours)};
			if (got.minute != want.minute)
				diff = {diff, $sformatf(" minute %0d/%0d", got.minute, want.minute)};
			if (got.hour != want.hour)
				diff = {diff, $sformatf(" hour %0d/%0d", got.hour, want.hour)};
			if (got.day != want.day)
				diff = {diff, $sformatf(" day %0d/%0d", got.day, want.day)};
			if (diff == "")
				return "";
			return {"result word (got/want):", diff};
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [OMP_SAMPLE_BITS-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic [BIN_W-1:0]           count_last_15_minutes;
	logic [BIN_W-1:0]           count_this_hour;
	logic [BIN_W-1:0]           count_all_hours;
	logic [MIN_W-1:0]           minute_now;
	logic [HOUR_W-1:0]          hour_now;
	logic [DAY_W-1:0]           day_now;

	pulse_tracker  tracker;
	int            mismatches;
	int            results_taken;
	int            stuck;
	bit            quiet_tx;
	bit            quiet_rx;
	int            rx_hold;
	int            rx_seen;
	pulse_report_t seen_report;
	string         verdict;

	// state of the random light pattern
	int flash_left;
	int flash_level;
	int steady_level;

	optical_meter_pulse_counter dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_ready              (in_ready),
		.sample                (sample),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.count_last_15_minutes (count_last_15_minutes),
		.count_this_hour       (count_this_hour),
		.count_all_hours       (count_all_hours),
		.minute_now            (minute_now),
		.hour_now              (hour_now),
		.day_now               (day_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// one sample word, after a random gap; returns at the accepting edge
	task automatic send_sample(input logic [OMP_SAMPLE_BITS-1:0] s);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		tracker.note_sample(s);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// sender holds off until every owed result word has come back
	task automatic drain_results();
		idle_input();
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// block fully idle: results drained and any pulse-free tick finished
	task automatic settle();
		drain_results();
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// mostly a steady level with short flashes of 1 to 3 ticks, some raw noise
	function automatic logic [OMP_SAMPLE_BITS-1:0] light_sample();
		if ($urandom_range(0, 9) < 3)
			return OMP_SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX)));
		if (flash_left > 0) begin
			flash_left--;
			return OMP_SAMPLE_BITS'(flash_level);
		end
		if ($urandom_range(0, 15) == 0)
			steady_level = $urandom_range(0, 3000);
		if ($urandom_range(0, 5) == 0) begin
			flash_left  = $urandom_range(0, 2);
			flash_level = steady_level + $urandom_range(0, int'(SAMPLE_MAX) - steady_level);
			return OMP_SAMPLE_BITS'(flash_level);
		end
		return OMP_SAMPLE_BITS'(steady_level + $urandom_range(0, 8));
	endfunction

	task automatic run_random(input int words);
		for (int i = 0; i < words; i++) begin
			// now and then the sender waits for the pipe to empty
			if ($urandom_range(0, 49) == 0)
				drain_results();
			// switch between gapped traffic and back-to-back bursts
			if ($urandom_range(0, 63) == 0)
				quiet_tx = !quiet_tx;
			send_sample(light_sample());
		end
		quiet_tx = 0;
	endtask

	// result side: random stall after each word, with bursts of no stall
	initial begin
		out_ready = 1'b0;
		rx_hold   = 0;
		rx_seen   = 0;
		quiet_rx  = 0;
		forever begin
			@(negedge clk);
			if (rx_seen != results_taken) begin
				rx_seen = results_taken;
				if ($urandom_range(0, 31) == 0)
					quiet_rx = !quiet_rx;
				rx_hold = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_report = '{
				window_sum: count_last_15_minutes,
				hour_total: count_this_hour,
				all_hours:  count_all_hours,
				minute:     minute_now,
				hour:       hour_now,
				day:        day_now
			};
			verdict = tracker.check(seen_report);
			if (verdict != "")
				report_mismatch(verdict);
			results_taken++;
		end
	end

	// watchdog: nothing moving on either channel for too long
	initial begin
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("tb_optical_meter_pulse_counter: FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_THRESHOLD;
		cfg_data      = '0;
		in_valid      = 1'b0;
		sample        = '0;
		quiet_tx      = 0;
		mismatches    = 0;
		results_taken = 0;
		flash_left    = 0;
		flash_level   = 0;
		steady_level  = 200;
		tracker       = new();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings: threshold 100, 1000 ticks per second
		// quiet start, then a full-scale flash counted once while it stays high
		send_sample('0);
		send_sample('0);
		send_sample('0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample('0);
		send_sample('0);
		send_sample(SAMPLE_MAX);
		send_sample('0);
		send_sample('0);
		send_sample('0);
		// exactly at the threshold: no pulse; one above: pulse, then held
		send_sample(tracker.at_margin(int'(tracker.threshold)));
		send_sample('0);
		send_sample(tracker.at_margin(int'(tracker.threshold) + 1));
		send_sample(tracker.at_margin(int'(tracker.threshold) + 1));
		// alternating bit patterns and the mid and low codes
		send_sample('0);
		send_sample(OMP_SAMPLE_BITS'(12'h555));
		send_sample(OMP_SAMPLE_BITS'(12'hAAA));
		send_sample(OMP_SAMPLE_BITS'(1));
		send_sample(OMP_SAMPLE_BITS'(12'h800));
		send_sample(SAMPLE_MAX);
		send_sample('0);

		// zero threshold, one tick per second; upper data bits must be dropped,
		// writes to unused indexes must change nothing
		settle();
		write_reg(REG_THRESHOLD, 16'hF000);
		write_reg(REG_TICKS, CFG_DATA_W'(1));
		write_reg(REG_SPARE_LOW, 16'hFFFF);
		write_reg(REG_SPARE_TOP, 16'h0001);
		run_random(400);

		// clock sweep over a few minutes, back to back, with sparse flashes
		settle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'(200));
		quiet_tx = 1;
		for (int i = 0; i < SWEEP_TICKS; i++)
			send_sample((i % FLASH_EVERY == FLASH_EVERY - 1) ? SAMPLE_MAX : '0);
		quiet_tx = 0;

		// two ticks per second, random threshold
		settle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 600)));
		write_reg(REG_TICKS, CFG_DATA_W'(2));
		run_random(400);

		// largest threshold (out of reach) and largest tick count
		settle();
		write_reg(REG_THRESHOLD, 16'hFFFF);
		write_reg(REG_TICKS, 16'hFFFF);
		run_random(100);

		// zero ticks per second: a second lasts a full counter wrap
		settle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 100)));
		write_reg(REG_TICKS, '0);
		run_random(150);

		// tick count lowered below the running counter: it runs on to the wrap
		settle();
		write_reg(REG_THRESHOLD, '0);
		write_reg(REG_TICKS, CFG_DATA_W'(5));
		run_random(300);

		settle();
		if (mismatches == 0)
			$display("tb_optical_meter_pulse_counter: PASS");
		else
			$display("tb_optical_meter_pulse_counter: FAIL");
		$finish;
	end

endmodule
